/* design/trf_pkg.sv */
// Package for the terminal receive filter.
// Holds byte codes, the parser state type and the result structures.
// No dependencies.
package trf_pkg;

    // Register values for the protocol variant
    localparam logic [1:0] VAR_NEW = 2'd0;
    localparam logic [1:0] VAR_OLD = 2'd1;

    // Byte codes
    localparam logic [7:0] B_NUL  = 8'o000;
    localparam logic [7:0] B_BS   = 8'o010;
    localparam logic [7:0] B_LF   = 8'o012;
    localparam logic [7:0] B_CR   = 8'o015;
    localparam logic [7:0] B_SP   = 8'o040;
    localparam logic [7:0] B_DEL  = 8'o177;
    localparam logic [7:0] B_MARK = 8'o200;
    localparam logic [7:0] B_IAC  = 8'o377;
    localparam logic [7:0] B_DONT = 8'o376;
    localparam logic [7:0] B_WILL = 8'o373;
    localparam logic [7:0] B_EC   = 8'o367;
    localparam logic [7:0] B_OLD_CTL_LO = 8'o201;
    localparam logic [7:0] B_OLD_CTL_HI = 8'o205;
    localparam logic [7:0] B_OLD_MODE_LO = 8'o240;
    localparam logic [7:0] B_OLD_MODE_HI = 8'o242;

    // Notice codes
    localparam logic [3:0] NOTE_CR_NO_LF = 4'd0;
    localparam logic [3:0] NOTE_MODE_BASE = 4'd6;

    typedef enum logic [1:0] {
        ST_NORMAL = 2'd0,
        ST_CMD    = 2'd1,
        ST_OPT    = 2'd2,
        ST_CR     = 2'd3
    } parse_state_t;

    localparam int MaxResults = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       is_notice;
        logic [3:0] code;
    } result_t;

    typedef struct packed {
        logic [1:0]                    count;
        result_t [MaxResults-1:0]      res;
        parse_state_t                  next_state;
    } decode_t;

endpackage

/* design/trf_decode.sv */
// Combinational decoder: one byte plus parser state gives 0..3 results and the next state.
// Depends on trf_pkg.
module trf_decode (
    input  logic [1:0]            variant,
    input  trf_pkg::parse_state_t state,
    input  logic [7:0]            in_byte,
    output trf_pkg::decode_t      dec
);
    import trf_pkg::*;

    function automatic result_t data_res(input logic [7:0] d);
        result_t r;
        r.data      = d;
        r.is_notice = 1'b0;
        r.code      = 4'd0;
        return r;
    endfunction

    function automatic result_t note_res(input logic [3:0] c);
        result_t r;
        r.data      = 8'd0;
        r.is_notice = 1'b1;
        r.code      = c;
        return r;
    endfunction

    logic old_drop;

    assign old_drop = (in_byte <= 8'o006) ||
                      (in_byte >= 8'o016 && in_byte <= 8'o032) ||
                      (in_byte >= 8'o034 && in_byte <= 8'o037) ||
                      (in_byte == B_DEL) || (in_byte == B_MARK);

    always_comb begin
        dec.count      = 2'd0;
        dec.res        = '0;
        dec.next_state = ST_NORMAL;
        unique case (variant)
            VAR_NEW: begin
                if (state == ST_CMD) begin
                    if (in_byte == B_IAC) begin
                        dec.count  = 2'd1;
                        dec.res[0] = data_res(B_IAC);
                    end else if (in_byte == B_EC) begin
                        dec.count  = 2'd3;
                        dec.res[0] = data_res(B_BS);
                        dec.res[1] = data_res(B_SP);
                        dec.res[2] = data_res(B_BS);
                    end else if (in_byte >= B_WILL && in_byte <= B_DONT) begin
                        dec.next_state = ST_OPT;
                    end
                end else if (state == ST_OPT) begin
                    // option byte swallowed
                end else if (in_byte == B_IAC) begin
                    dec.next_state = ST_CMD;
                end else if (in_byte != B_NUL) begin
                    dec.count  = 2'd1;
                    dec.res[0] = data_res(in_byte);
                end
            end
            VAR_OLD: begin
                if (state == ST_CR) begin
                    if (in_byte == B_NUL) begin
                        dec.count  = 2'd1;
                        dec.res[0] = data_res(B_CR);
                    end else if (in_byte == B_LF) begin
                        dec.count  = 2'd2;
                        dec.res[0] = data_res(B_CR);
                        dec.res[1] = data_res(B_LF);
                    end else begin
                        dec.count  = 2'd1;
                        dec.res[0] = note_res(NOTE_CR_NO_LF);
                    end
                end else if (in_byte == B_CR) begin
                    dec.next_state = ST_CR;
                end else if (old_drop) begin
                    // dropped control code
                end else if (in_byte >= B_OLD_CTL_LO && in_byte <= B_OLD_CTL_HI) begin
                    dec.count  = 2'd1;
                    dec.res[0] = note_res(in_byte[3:0]);
                end else if (in_byte >= B_OLD_MODE_LO && in_byte <= B_OLD_MODE_HI) begin
                    dec.count  = 2'd1;
                    dec.res[0] = note_res(NOTE_MODE_BASE + {2'b00, in_byte[1:0]});
                end else begin
                    dec.count  = 2'd1;
                    dec.res[0] = data_res(in_byte);
                end
            end
            default: begin
                // binary passthrough, also the unused code
                dec.count  = 2'd1;
                dec.res[0] = data_res(in_byte);
            end
        endcase
    end

endmodule

/* design/trf_result_buf.sv */
// Result register: holds the results of one byte and sends them out one per transaction.
// Depends on trf_pkg.
module trf_result_buf (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  trf_pkg::decode_t dec,
    output logic             free_next,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic [4:0]       m_tuser,   // [0] is_notice, [4:1] notice_code
    output logic             m_tlast
);
    import trf_pkg::*;

    result_t [MaxResults-1:0] res_reg;
    logic [1:0] cnt_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       is_last;
    result_t    cur;

    assign cur       = res_reg[idx_reg];
    assign is_last   = (idx_reg == cnt_reg - 2'd1);
    assign free_next = !valid_reg || (m_tready && is_last);

    assign m_tvalid = valid_reg;
    assign m_tdata  = cur.data;
    assign m_tuser  = {cur.code, cur.is_notice};
    assign m_tlast  = is_last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            cnt_reg   <= 2'd0;
            idx_reg   <= 2'd0;
        end else if (load) begin
            valid_reg <= 1'b1;
            cnt_reg   <= dec.count;
            idx_reg   <= 2'd0;
        end else if (valid_reg && m_tready) begin
            if (is_last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            res_reg <= dec.res;
        end
    end

endmodule

/* design/telnet_receive_filter.sv */
// Top level of the terminal receive filter.
// Depends on trf_pkg, trf_decode and trf_result_buf.
//
// Receive-side byte filter for a terminal link. Each byte accepted on the s_ stream is
// decoded under the protocol variant held in the configuration register (0 command-escaped,
// 1 old protocol, 2 or 3 binary passthrough) and yields zero to three results on the m_
// stream. A result is a data byte (m_tuser[0] low) or a notice (m_tuser[0] high, code in
// m_tuser[4:1]); m_tlast marks the final result of each input byte. Bytes that give no
// result produce no output transaction at all. Rate: one byte per cycle when each byte gives
// at most one result and the m_ stream is not stalled; a byte giving several results holds
// the result register until each of them is taken, and the input waits meanwhile. Each
// input transaction passes an input register, then the decode into the result register.
// Writing the register (cfg_we) also returns the parser to its normal state; write only
// while the block is idle.
module telnet_receive_filter (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration
    input  logic       cfg_we,
    input  logic [1:0] cfg_wdata,   // [1:0] protocol_variant
    // input stream
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,     // [7:0] in_byte
    // result stream
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,     // [7:0] out_byte
    output logic [4:0] m_tuser,     // [0] is_notice, [4:1] notice_code
    output logic       m_tlast
);
    import trf_pkg::*;

    logic [1:0]   variant_reg;
    parse_state_t state_reg, state_next;
    logic         in_valid_reg;
    logic [7:0]   in_byte_reg;

    decode_t dec;
    logic    free_next;
    logic    advance;   // input register consumed by the decoder this cycle
    logic    load;      // decoded results written into the result register

    trf_decode u_decode (
        .variant (variant_reg),
        .state   (state_reg),
        .in_byte (in_byte_reg),
        .dec     (dec)
    );

    // A byte with no results never waits on the output side.
    assign advance  = in_valid_reg && ((dec.count == 2'd0) || free_next);
    assign load     = advance && (dec.count != 2'd0);
    assign s_tready = !in_valid_reg || advance;

    trf_result_buf u_result_buf (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .dec       (dec),
        .free_next (free_next),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Configuration register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            variant_reg <= VAR_NEW;
        end else if (cfg_we) begin
            variant_reg <= cfg_wdata;
        end
    end

    // Parser state: a register write abandons any partial sequence
    always_comb begin
        state_next = state_reg;
        if (cfg_we) begin
            state_next = ST_NORMAL;
        end else if (advance) begin
            state_next = dec.next_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_NORMAL;
        end else begin
            state_reg <= state_next;
        end
    end

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
        end
    end

endmodule

/* bench/tb_top.sv */
// Self-checking bench for telnet_receive_filter: directed and random byte traffic
// under every protocol variant, results checked against an in-bench filter model.
// Depends on trf_pkg and the telnet_receive_filter RTL.
module tb_top;
    import trf_pkg::*;

    // Variant codes the package leaves out
    localparam logic [1:0] VAR_BIN   = 2'd2;
    localparam logic [1:0] VAR_SPARE = 2'd3;   // unused code, acts as binary

    // Old-protocol control ranges that are silently dropped
    localparam logic [7:0] CTL_A_LO = 8'o001;
    localparam logic [7:0] CTL_A_HI = 8'o006;
    localparam logic [7:0] CTL_B_LO = 8'o016;
    localparam logic [7:0] CTL_B_HI = 8'o032;
    localparam logic [7:0] CTL_C_LO = 8'o034;
    localparam logic [7:0] CTL_C_HI = 8'o037;

    // Command bytes used only by the stimulus
    localparam logic [7:0] B_DO   = 8'o375;
    localparam logic [7:0] B_WONT = 8'o374;
    localparam logic [7:0] B_NOP  = 8'o361;

    localparam int DRAIN_CYCLES   = 6;     // input reg + result reg, with margin
    localparam int WATCHDOG_LIMIT = 2000;  // above the longest result hold-off (HOLD_CYCLES)
    localparam int HOLD_CYCLES    = 300;

    typedef struct {
        logic [7:0] data;
        logic       is_notice;
        logic [3:0] code;
        logic       last;
    } term_result_t;

    logic       aclk;
    logic       aresetn;
    logic       cfg_we;
    logic [1:0] cfg_wdata;
    logic       s_tvalid;
    logic       s_tready;
    logic [7:0] s_tdata;
    logic       m_tvalid;
    logic       m_tready;
    logic [7:0] m_tdata;
    logic [4:0] m_tuser;
    logic       m_tlast;

    telnet_receive_filter dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // Model state: mirrors the register and the parser inside the block
    logic [1:0]   filter_variant;
    parse_state_t filter_state;

    term_result_t expected_results[$];

    int error_count    = 0;
    int bytes_sent     = 0;
    int results_seen   = 0;
    int notices_seen   = 0;
    int send_idle_pct  = 0;
    int stall_pct      = 0;
    int hold_request   = 0;
    int idle_cycles    = 0;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Filter model
    // ------------------------------------------------------------------
    function automatic term_result_t data_result(input logic [7:0] b);
        term_result_t r;
        r = '{data: b, is_notice: 1'b0, code: 4'd0, last: 1'b0};
        return r;
    endfunction

    function automatic term_result_t notice_result(input logic [3:0] c);
        term_result_t r;
        r = '{data: 8'd0, is_notice: 1'b1, code: c, last: 1'b0};
        return r;
    endfunction

    // Works out what one accepted byte produces and queues it.
    task automatic predict_filter(input logic [7:0] b);
        term_result_t burst[$];
        if (filter_variant == VAR_NEW) begin
            case (filter_state)
                ST_CMD: begin
                    filter_state = ST_NORMAL;
                    if (b == B_IAC) begin
                        burst.push_back(data_result(B_IAC));
                    end else if (b == B_EC) begin
                        // erase character: BS SP BS
                        burst.push_back(data_result(B_BS));
                        burst.push_back(data_result(B_SP));
                        burst.push_back(data_result(B_BS));
                    end else if (b >= B_WILL && b <= B_DONT) begin
                        filter_state = ST_OPT;
                    end
                end
                ST_OPT: begin
                    filter_state = ST_NORMAL;   // option byte swallowed
                end
                default: begin
                    filter_state = ST_NORMAL;
                    if (b == B_IAC) begin
                        filter_state = ST_CMD;
                    end else if (b != B_NUL) begin
                        burst.push_back(data_result(b));
                    end
                end
            endcase
        end else if (filter_variant == VAR_OLD) begin
            if (filter_state == ST_CR) begin
                filter_state = ST_NORMAL;
                if (b == B_NUL) begin
                    burst.push_back(data_result(B_CR));
                end else if (b == B_LF) begin
                    burst.push_back(data_result(B_CR));
                    burst.push_back(data_result(B_LF));
                end else begin
                    burst.push_back(notice_result(NOTE_CR_NO_LF));
                end
            end else begin
                filter_state = ST_NORMAL;
                if (b == B_CR) begin
                    filter_state = ST_CR;
                end else if (b == B_NUL || (b >= CTL_A_LO && b <= CTL_A_HI)
                        || (b >= CTL_B_LO && b <= CTL_B_HI)
                        || (b >= CTL_C_LO && b <= CTL_C_HI)
                        || b == B_DEL || b == B_MARK) begin
                    // dropped
                end else if (b >= B_OLD_CTL_LO && b <= B_OLD_CTL_HI) begin
                    burst.push_back(notice_result(4'(b - B_MARK)));
                end else if (b >= B_OLD_MODE_LO && b <= B_OLD_MODE_HI) begin
                    burst.push_back(notice_result(4'(b - B_OLD_MODE_LO) + NOTE_MODE_BASE));
                end else begin
                    burst.push_back(data_result(b));
                end
            end
        end else begin
            filter_state = ST_NORMAL;
            burst.push_back(data_result(b));
        end
        if (burst.size() > 0)
            burst[burst.size()-1].last = 1'b1;
        foreach (burst[i])
            expected_results.push_back(burst[i]);
    endtask

    // ------------------------------------------------------------------
    // Result side: random stalls plus an occasional long hold-off
    // ------------------------------------------------------------------
    initial begin
        int hold_left;
        hold_left = 0;
        m_tready  = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                m_tready  = 1'b0;
                hold_left = hold_left - 1;
            end else begin
                m_tready = ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    task automatic report_mismatch(input string what);
        $display("MISMATCH at result %0d: %s", results_seen, what);
        error_count++;
    endtask

    // Every result transaction is compared with the oldest expectation
    always @(posedge aclk) begin
        term_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser[0])
                notices_seen++;
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result data=%02h user=%02h",
                                          m_tdata, m_tuser));
            end else begin
                want = expected_results.pop_front();
                if (m_tuser[0] !== want.is_notice)
                    report_mismatch($sformatf("is_notice %b, want %b",
                                              m_tuser[0], want.is_notice));
                if (m_tdata !== want.data)
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              m_tdata, want.data));
                if (m_tuser[4:1] !== want.code)
                    report_mismatch($sformatf("notice_code %0d, want %0d",
                                              m_tuser[4:1], want.code));
                if (m_tlast !== want.last)
                    report_mismatch($sformatf("last %b, want %b", m_tlast, want.last));
            end
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles, %0d results pending",
                     idle_cycles, expected_results.size());
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    // Offers one byte, with random gaps ahead of it, and predicts on acceptance.
    // tvalid is left high so back-to-back bytes need no re-assert.
    task automatic send_byte(input logic [7:0] b);
        @(negedge aclk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
        predict_filter(b);
    endtask

    // Stops offering and waits until every expected result is out, then
    // lets trailing no-result bytes clear the pipeline.
    task automatic drain;
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (expected_results.size() != 0)
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // Register write, only with the block idle; also resets the parser.
    task automatic set_variant(input logic [1:0] v);
        drain();
        cfg_we    = 1'b1;
        cfg_wdata = v;
        @(negedge aclk);
        cfg_we         = 1'b0;
        filter_variant = v;
        filter_state   = ST_NORMAL;
    endtask

    task automatic send_list(input logic [7:0] bytes[]);
        foreach (bytes[i])
            send_byte(bytes[i]);
    endtask

    // Half well-formed command sequences with random content, the rest single random bytes or NUL
    task automatic send_new_sequence;
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3: send_byte(8'($urandom_range(0, 255)));
            4: begin
                send_byte(B_IAC);
                send_byte(B_IAC);
            end
            5: begin
                send_byte(B_IAC);
                send_byte(B_EC);
            end
            6, 7: begin
                send_byte(B_IAC);
                send_byte(8'($urandom_range(B_WILL, B_DONT)));
                send_byte(8'($urandom_range(0, 255)));
            end
            8: begin
                send_byte(B_IAC);
                send_byte(8'($urandom_range(0, 255)));
            end
            default: send_byte(B_NUL);
        endcase
    endtask

    task automatic send_old_sequence;
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1, 2, 3: send_byte(8'($urandom_range(0, 255)));
            4: begin
                send_byte(B_CR);
                send_byte(B_NUL);
            end
            5: begin
                send_byte(B_CR);
                send_byte(B_LF);
            end
            6: begin
                send_byte(B_CR);
                send_byte(8'($urandom_range(0, 255)));
            end
            7: send_byte(8'($urandom_range(B_OLD_CTL_LO, B_OLD_CTL_HI)));
            8: send_byte(8'($urandom_range(B_OLD_MODE_LO, B_OLD_MODE_HI)));
            default: send_byte(8'($urandom_range(0, CTL_C_HI)));
        endcase
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_new_directed;
        set_variant(VAR_NEW);
        send_list('{B_NUL, 8'h41, B_DEL, B_MARK, B_DONT,
                    B_IAC, B_IAC,               // escaped 0xFF
                    B_IAC, B_EC,                // erase character
                    B_IAC, B_DO, 8'h01,         // option swallowed
                    B_IAC, B_WILL, B_IAC,       // option byte may be IAC
                    B_IAC, B_DONT, 8'h00,
                    B_IAC, B_WONT, 8'h18,
                    B_IAC, B_NOP,               // other command dropped
                    B_IAC, B_NUL, 8'h7E});
    endtask

    task automatic test_old_directed;
        set_variant(VAR_OLD);
        send_list('{B_NUL, CTL_A_LO, CTL_A_HI, 8'o007, CTL_B_LO, CTL_B_HI, 8'o033,
                    CTL_C_LO, CTL_C_HI, B_DEL, B_MARK,
                    8'o201, 8'o202, 8'o203, 8'o204, 8'o205,   // old control notices
                    8'o240, 8'o241, 8'o242, 8'o243,           // mode notices, then 0o243 as data
                    B_CR, B_NUL, B_CR, B_LF, B_CR, 8'h41,
                    B_CR, B_CR, B_LF, B_IAC});
    endtask

    task automatic test_binary_directed;
        set_variant(VAR_BIN);
        send_list('{B_NUL, B_IAC, B_EC, B_CR, B_LF, 8'h80});
        set_variant(VAR_SPARE);
        send_list('{B_NUL, B_IAC, B_IAC, B_CR, 8'h7F});
    endtask

    // A register write in the middle of a sequence abandons it
    task automatic test_variant_change;
        set_variant(VAR_NEW);
        send_list('{8'h31, B_IAC});
        set_variant(VAR_NEW);
        send_list('{B_EC, B_IAC, B_DO});
        set_variant(VAR_OLD);
        send_list('{B_CR});
        set_variant(VAR_NEW);
        send_list('{B_LF});
        set_variant(VAR_OLD);
        send_list('{B_CR});
        set_variant(VAR_BIN);
        send_list('{B_NUL});
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall, input int n_new,
                                       input int n_old, input int n_bin,
                                       input logic [1:0] bin_code);
        int stop_at;
        send_idle_pct = idle_pct;
        stall_pct     = stall;
        set_variant(VAR_NEW);
        stop_at = bytes_sent + n_new;
        while (bytes_sent < stop_at)
            send_new_sequence();
        set_variant(VAR_OLD);
        stop_at = bytes_sent + n_old;
        while (bytes_sent < stop_at)
            send_old_sequence();
        set_variant(bin_code);
        repeat (n_bin) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Receiver holds off for a long stretch while the sender keeps offering,
    // so the result register fills and the input stalls.
    task automatic test_backpressure;
        send_idle_pct = 0;
        stall_pct     = 0;
        set_variant(VAR_NEW);
        @(posedge aclk);
        hold_request = HOLD_CYCLES;
        repeat (8) begin
            send_list('{B_IAC, B_EC});
            send_new_sequence();
        end
        drain();
        hold_request = HOLD_CYCLES;
        set_variant(VAR_OLD);
        repeat (20) send_old_sequence();
    endtask

    initial begin
        int first_random;
        aresetn        = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = VAR_NEW;
        s_tvalid       = 1'b0;
        s_tdata        = 8'd0;
        filter_variant = VAR_NEW;
        filter_state   = ST_NORMAL;
        repeat (8) @(negedge aclk);
        aresetn = 1'b1;

        test_new_directed();
        test_old_directed();
        test_binary_directed();
        test_variant_change();
        first_random = bytes_sent;
        test_random_traffic(0,  0,  22, 22, 10, VAR_BIN);
        test_random_traffic(49, 0,  22, 22, 10, VAR_SPARE);
        test_random_traffic(0,  49, 22, 22, 10, VAR_BIN);
        test_random_traffic(28, 28, 22, 22, 10, VAR_SPARE);
        test_backpressure();
        drain();

        $display("Sent %0d bytes (%0d random) over all four protocol codes, with and without",
                 bytes_sent, bytes_sent - first_random);
        $display("idling and a long result hold-off; checked %0d results, %0d of them notices.",
                 results_seen, notices_seen);
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
